### src/ktsort_pkg.sv
// ktsort_pkg: shared sizes, command codes and controller/datapath interface structs
// for the topological sort core
// no dependencies
package ktsort_pkg;

  // sizing
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VERTEX_W     = 7;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);
  localparam int VQ_W         = VTX_AW + 1;
  localparam int EDGE_AW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W        = $clog2(MAX_EDGES + 1);
  localparam int IDX_W        = (CNT_W > VQ_W) ? CNT_W : VQ_W;
  localparam int DEG_W        = CNT_W;

  // configuration register map
  localparam int                  CFG_AW           = 3;
  localparam logic                REG_VERTEX_COUNT = 1'b0;
  localparam logic [VERTEX_W-1:0] VC_RESET         = VERTEX_W'(64);

  // input command codes
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic run_start;
    logic idx_clr;
    logic idx_inc;
    logic deg_clr;
    logic deg_vtx_sel;
    logic cnt_upd;
    logic seed_chk;
    logic scan_upd;
    logic pop;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_clr_done;
    logic idx_lt_total;
    logic idx_lt_n;
    logic cnt_hit;
    logic scan_hit;
    logic q_nonempty;
    logic out_free;
    logic pend_valid;
  } dp_sts_t;

  // vertex count saturated to the vertex capacity
  function automatic logic [VERTEX_W-1:0] sat_count(input logic [VERTEX_W-1:0] vc);
    logic [VERTEX_W-1:0] lim;
    lim = VERTEX_W'(MAX_VERTICES);
    return (vc > lim) ? lim : vc;
  endfunction

endpackage

### src/ktsort_dp.sv
// ktsort_dp: datapath of the topological sort core: edge store, in-degree table,
// ready queue, counters and output register
// depends on ktsort_pkg
module ktsort_dp import ktsort_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VERTEX_W-1:0] n_i,
  input  logic [VERTEX_W-1:0] from_i,
  input  logic [VERTEX_W-1:0] to_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_has_o,
  output logic [VERTEX_W-1:0] out_vertex_o,
  output logic                out_last_o,
  output logic                out_cycle_o,
  output logic                out_drop_o
);

  // stores
  logic [2*VTX_AW-1:0] edge_mem [MAX_EDGES];
  logic [DEG_W-1:0]    deg_mem  [MAX_VERTICES];
  logic [VTX_AW-1:0]   q_mem    [MAX_VERTICES];

  logic [2*VTX_AW-1:0] edge_rd_r;
  logic [DEG_W-1:0]    deg_rd_r;
  logic [VTX_AW-1:0]   q_rd_r;

  logic [CNT_W-1:0]    edge_total_r;
  logic                dropped_r;
  logic [IDX_W-1:0]    idx_r;
  logic [VQ_W-1:0]     head_r;
  logic [VQ_W-1:0]     tail_r;
  logic                pend_valid_r;
  logic [VTX_AW-1:0]   pend_vtx_r;

  logic                out_valid_r;
  logic                out_has_r;
  logic [VERTEX_W-1:0] out_vertex_r;
  logic                out_last_r;
  logic                out_cycle_r;
  logic                out_drop_r;

  logic [VERTEX_W-1:0] from_m1;
  logic [VERTEX_W-1:0] to_m1;
  logic                edge_ok;
  logic [VTX_AW-1:0]   e_src;
  logic [VTX_AW-1:0]   e_tgt;
  logic [VTX_AW-1:0]   deg_raddr;
  logic                deg_we;
  logic [VTX_AW-1:0]   deg_waddr;
  logic [DEG_W-1:0]    deg_wdata;
  logic                push;
  logic [VTX_AW-1:0]   push_vtx;
  logic                emit;
  logic                out_free;

  // load checks
  assign from_m1 = from_i - VERTEX_W'(1);
  assign to_m1   = to_i - VERTEX_W'(1);
  assign edge_ok = (from_i != '0) && (to_i != '0) && (from_i <= n_i) && (to_i <= n_i) &&
                   (edge_total_r < CNT_W'(MAX_EDGES));

  assign e_src = edge_rd_r[2*VTX_AW-1:VTX_AW];
  assign e_tgt = edge_rd_r[VTX_AW-1:0];

  // edge store, read every cycle at the scan index
  always_ff @(posedge clk) begin
    if (cmd_i.load && edge_ok) begin
      edge_mem[edge_total_r[EDGE_AW-1:0]] <= {from_m1[VTX_AW-1:0], to_m1[VTX_AW-1:0]};
    end
    edge_rd_r <= edge_mem[idx_r[EDGE_AW-1:0]];
  end

  // in-degree table write port
  assign deg_raddr = cmd_i.deg_vtx_sel ? idx_r[VTX_AW-1:0] : e_tgt;

  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = e_tgt;
    deg_wdata = deg_rd_r;
    priority if (cmd_i.deg_clr) begin
      deg_we    = 1'b1;
      deg_waddr = idx_r[VTX_AW-1:0];
      deg_wdata = '0;
    end else if (cmd_i.cnt_upd) begin
      deg_we    = 1'b1;
      deg_wdata = deg_rd_r + DEG_W'(1);
    end else if (cmd_i.scan_upd && (deg_rd_r != '0)) begin
      deg_we    = 1'b1;
      deg_wdata = deg_rd_r - DEG_W'(1);
    end else begin
      deg_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd_r <= deg_mem[deg_raddr];
  end

  // ready queue pushes
  always_comb begin
    push     = 1'b0;
    push_vtx = e_tgt;
    priority if (cmd_i.seed_chk) begin
      push     = (deg_rd_r == '0);
      push_vtx = idx_r[VTX_AW-1:0];
    end else if (cmd_i.scan_upd) begin
      push     = (deg_rd_r == DEG_W'(1));
    end else begin
      push     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail_r[VTX_AW-1:0]] <= push_vtx;
    end
    q_rd_r <= q_mem[head_r[VTX_AW-1:0]];
  end

  // counters and pending vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      dropped_r    <= 1'b0;
      idx_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (edge_ok) begin
          edge_total_r <= edge_total_r + CNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        edge_total_r <= '0;
        dropped_r    <= 1'b0;
      end
      if (cmd_i.run_start || cmd_i.idx_clr) begin
        idx_r <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd_i.run_start) begin
        head_r       <= '0;
        tail_r       <= '0;
        pend_valid_r <= 1'b0;
      end else begin
        if (push) begin
          tail_r <= tail_r + VQ_W'(1);
        end
        if (cmd_i.pop) begin
          head_r       <= head_r + VQ_W'(1);
          pend_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.pop) begin
      pend_vtx_r <= q_rd_r;
    end
  end

  // output register
  assign out_free = !out_valid_r || out_ready_i;
  assign emit     = (cmd_i.pop && pend_valid_r) || cmd_i.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_has_r    <= pend_valid_r;
      out_vertex_r <= pend_valid_r ? (VERTEX_W'(pend_vtx_r) + VERTEX_W'(1)) : '0;
      out_last_r   <= cmd_i.finish;
      out_cycle_r  <= cmd_i.finish && (VERTEX_W'(tail_r) < n_i);
      out_drop_r   <= cmd_i.finish && dropped_r;
    end
  end

  assign out_valid_o  = out_valid_r;
  assign out_has_o    = out_has_r;
  assign out_vertex_o = out_vertex_r;
  assign out_last_o   = out_last_r;
  assign out_cycle_o  = out_cycle_r;
  assign out_drop_o   = out_drop_r;

  // status
  assign sts_o.idx_clr_done = (idx_r == IDX_W'(MAX_VERTICES - 1));
  assign sts_o.idx_lt_total = (idx_r < IDX_W'(edge_total_r));
  assign sts_o.idx_lt_n     = (idx_r < IDX_W'(n_i));
  assign sts_o.cnt_hit      = (VERTEX_W'(e_src) < n_i) && (VERTEX_W'(e_tgt) < n_i);
  assign sts_o.scan_hit     = (e_src == pend_vtx_r) && (VERTEX_W'(e_tgt) < n_i);
  assign sts_o.q_nonempty   = (head_r != tail_r);
  assign sts_o.out_free     = out_free;
  assign sts_o.pend_valid   = pend_valid_r;

`ifndef NO_ASSERTIONS
  // each vertex enters the queue at most once
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= VQ_W'(MAX_VERTICES))
    else $error("ready queue tail beyond vertex capacity");

  // never pop past the tail
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("ready queue head passed tail");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= CNT_W'(MAX_EDGES))
    else $error("edge count beyond store capacity");

  // the store and drop mark are empty after a run
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |=> (edge_total_r == '0) && !dropped_r)
    else $error("edge store not cleared after run");

  // an emitted beat never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result register overrun");
`endif

endmodule

### src/ktsort_ctrl.sv
// ktsort_ctrl: controller state machine sequencing load, count, seed and pop phases
// depends on ktsort_pkg
module ktsort_ctrl import ktsort_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid_i,
  input  cmd_t    in_cmd_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_DEG,
    ST_CNT_WR,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP_RD,
    ST_POP_EMIT,
    ST_SCAN_RD,
    ST_SCAN_DEG,
    ST_SCAN_WR,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready_o = (state_r == ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_RUN) begin
            cmd_o.run_start = 1'b1;
            state_nxt       = ST_CLR;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      // zero the in-degree table
      ST_CLR: begin
        cmd_o.deg_clr = 1'b1;
        if (sts_i.idx_clr_done) begin
          cmd_o.idx_clr = 1'b1;
          state_nxt     = ST_CNT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      // count in-degrees over the edge store
      ST_CNT_RD: begin
        if (sts_i.idx_lt_total) begin
          state_nxt = ST_CNT_DEG;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_nxt     = ST_SEED_RD;
        end
      end
      ST_CNT_DEG: begin
        if (sts_i.cnt_hit) begin
          state_nxt = ST_CNT_WR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_nxt     = ST_CNT_RD;
        end
      end
      ST_CNT_WR: begin
        cmd_o.cnt_upd = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_nxt     = ST_CNT_RD;
      end
      // queue zero in-degree vertices in ascending order
      ST_SEED_RD: begin
        cmd_o.deg_vtx_sel = 1'b1;
        state_nxt         = sts_i.idx_lt_n ? ST_SEED_CHK : ST_POP_RD;
      end
      ST_SEED_CHK: begin
        cmd_o.deg_vtx_sel = 1'b1;
        cmd_o.seed_chk    = 1'b1;
        cmd_o.idx_inc     = 1'b1;
        state_nxt         = ST_SEED_RD;
      end
      // pop the queue
      ST_POP_RD: begin
        state_nxt = sts_i.q_nonempty ? ST_POP_EMIT : ST_FIN;
      end
      ST_POP_EMIT: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.pop     = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      // walk the out-edges of the popped vertex
      ST_SCAN_RD: begin
        state_nxt = sts_i.idx_lt_total ? ST_SCAN_DEG : ST_POP_RD;
      end
      ST_SCAN_DEG: begin
        if (sts_i.scan_hit) begin
          state_nxt = ST_SCAN_WR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_SCAN_WR: begin
        cmd_o.scan_upd = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_nxt      = ST_SCAN_RD;
      end
      // final beat of the run
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/kahn_topological_sort_core.sv
// kahn_topological_sort_core: add-edge beats are taken one beat per cycle while the core is idle.
// a run beat clears the in-degrees, counts the edges with both ends in range and seeds the queue,
// then for each popped vertex walks the whole edge store to update its matching out-edges,
// then closes the run with a final beat.
// synchronous active-low reset: edge store empty, drop flag clear, vertex_count = 64.
// depends on ktsort_pkg, ktsort_ctrl, ktsort_dp
module kahn_topological_sort_core import ktsort_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [6:0] from_vertex, [13:7] to_vertex, [15:14] zero
  input  logic [0:0]        in_tuser,   // [0] cmd
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [6:0] sorted_vertex, [7] cycle_found,
                                        // [8] edge_dropped, [15:9] zero
  output logic [0:0]        out_tuser,  // [0] has_vertex
  output logic              out_tlast,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [VERTEX_W-1:0] vertex_count_r;
  logic [VERTEX_W-1:0] n_eff;
  logic                cfg_wr;
  dp_cmd_t             dp_cmd;
  dp_sts_t             dp_sts;
  cmd_t                in_cmd;
  logic [VERTEX_W-1:0] out_vertex;
  logic                out_cycle;
  logic                out_drop;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VC_RESET;
    end else if (cfg_wr) begin
      vertex_count_r <= cfg_pwdata[VERTEX_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_VERTEX_COUNT) ?
                      {{(32-VERTEX_W){1'b0}}, vertex_count_r} : '0;

  assign n_eff  = sat_count(vertex_count_r);
  assign in_cmd = cmd_t'(in_tuser[0]);

  ktsort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_cmd_i   (in_cmd),
    .in_ready_o (in_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  ktsort_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .n_i          (n_eff),
    .from_i       (in_tdata[6:0]),
    .to_i         (in_tdata[13:7]),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .out_ready_i  (out_tready),
    .out_valid_o  (out_tvalid),
    .out_has_o    (out_tuser[0]),
    .out_vertex_o (out_vertex),
    .out_last_o   (out_tlast),
    .out_cycle_o  (out_cycle),
    .out_drop_o   (out_drop)
  );

  // result beat packing
  assign out_tdata = {7'd0, out_drop, out_cycle, out_vertex};

endmodule
